>>> hw/rtl/ntwa_pkg.sv
`timescale 1ns / 1ps
package ntwa_pkg;
    localparam logic [2:0] CMD_UPDATE = 3'd0;
    localparam logic [2:0] CMD_LOOKUP = 3'd1;
    localparam logic [2:0] CMD_REMOVE = 3'd2;
    localparam logic [2:0] CMD_EXPIRE = 3'd3;
    localparam logic [2:0] CMD_CLEAR  = 3'd4;

    localparam logic [1:0] ST_EMPTY  = 2'd0;
    localparam logic [1:0] ST_ACTIVE = 2'd1;
    localparam logic [1:0] ST_STALE  = 2'd2;

    localparam logic [1:0] RES_OK        = 2'd0;
    localparam logic [1:0] RES_INVALID   = 2'd1;
    localparam logic [1:0] RES_FULL      = 2'd2;
    localparam logic [1:0] RES_NOT_FOUND = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_ACT,
        S_READ,
        S_DONE
    } t_state;

    // Controller to datapath.
    typedef struct packed {
        logic load;      // capture the input word
        logic scan_clr;  // restart the slot scan
        logic scan_step; // examine one slot
        logic act;       // apply the command to the chosen slot
        logic rd;        // read the chosen slot's payload
        logic finish;    // build the result word
    } t_ctl;

    // Datapath to controller.
    typedef struct packed {
        logic scan_last;
    } t_sts;
endpackage

>>> hw/rtl/ntwa_if.sv
`timescale 1ns / 1ps
interface ntwa_in_if #(parameter int KEY_BITS = 48, parameter int LINK_BITS = 48);
    logic                 valid;
    logic                 ready;
    logic [2:0]           cmd;
    logic [KEY_BITS-1:0]  node_address;
    logic [LINK_BITS-1:0] link_address;
    logic [7:0]           node_role;
    logic [15:0]          capability_bits;
    logic [15:0]          seq_number;
    logic signed [7:0]    signal_strength;
    logic [31:0]          now_time;
    modport source(output valid, cmd, node_address, link_address, node_role,
                   capability_bits, seq_number, signal_strength, now_time,
                   input ready);
    modport sink(input valid, cmd, node_address, link_address, node_role,
                 capability_bits, seq_number, signal_strength, now_time,
                 output ready);
endinterface

interface ntwa_out_if #(parameter int LINK_BITS = 48);
    logic                 valid;
    logic                 ready;
    logic [1:0]           status;
    logic [3:0]           slot_index;
    logic [1:0]           entry_status;
    logic [LINK_BITS-1:0] found_link_address;
    logic [7:0]           found_role;
    logic [15:0]          found_capabilities;
    logic [15:0]          found_sequence;
    logic signed [7:0]    found_strength;
    logic [31:0]          found_last_seen;
    logic [4:0]           expired_count;
    logic [4:0]           occupied_count;
    modport source(output valid, status, slot_index, entry_status, found_link_address,
                   found_role, found_capabilities, found_sequence, found_strength,
                   found_last_seen, expired_count, occupied_count, input ready);
    modport sink(input valid, status, slot_index, entry_status, found_link_address,
                 found_role, found_capabilities, found_sequence, found_strength,
                 found_last_seen, expired_count, occupied_count, output ready);
endinterface

>>> hw/rtl/ntwa_ctrl.sv
`timescale 1ns / 1ps
module ntwa_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    input  ntwa_pkg::t_sts i_sts,
    output ntwa_pkg::t_ctl o_ctl
);
    ntwa_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ntwa_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ntwa_pkg::S_IDLE: begin
                if (i_in_valid) n_state = ntwa_pkg::S_SCAN;
            end
            ntwa_pkg::S_SCAN: begin
                if (i_sts.scan_last) n_state = ntwa_pkg::S_ACT;
            end
            ntwa_pkg::S_ACT:  n_state = ntwa_pkg::S_READ;
            ntwa_pkg::S_READ: n_state = ntwa_pkg::S_DONE;
            ntwa_pkg::S_DONE: begin
                if (i_out_ready) n_state = ntwa_pkg::S_IDLE;
            end
            default: n_state = ntwa_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_ctl       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            ntwa_pkg::S_IDLE: begin
                o_in_ready   = 1'b1;
                o_ctl.load     = i_in_valid;
                o_ctl.scan_clr = 1'b1;
            end
            ntwa_pkg::S_SCAN: o_ctl.scan_step = 1'b1;
            ntwa_pkg::S_ACT:  o_ctl.act = 1'b1;
            ntwa_pkg::S_READ: begin
                o_ctl.rd     = 1'b1;
            end
            ntwa_pkg::S_DONE: o_out_valid = 1'b1;
            default: ;
        endcase
        o_ctl.finish = (r_state == ntwa_pkg::S_READ);
    end
endmodule

>>> hw/rtl/ntwa_datapath.sv
`timescale 1ns / 1ps
module ntwa_datapath #(
    parameter int ENTRIES   = 16,
    parameter int KEY_BITS  = 48,
    parameter int LINK_BITS = 48
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ntwa_pkg::t_ctl       i_ctl,
    output ntwa_pkg::t_sts       o_sts,
    input  logic                 i_cfg_we,
    input  logic [31:0]          i_cfg_data,
    input  logic [2:0]           i_cmd,
    input  logic [KEY_BITS-1:0]  i_node_address,
    input  logic [LINK_BITS-1:0] i_link_address,
    input  logic [7:0]           i_node_role,
    input  logic [15:0]          i_capability_bits,
    input  logic [15:0]          i_seq_number,
    input  logic [7:0]           i_signal_strength,
    input  logic [31:0]          i_now_time,
    output logic [1:0]           o_status,
    output logic [3:0]           o_slot_index,
    output logic [1:0]           o_entry_status,
    output logic [LINK_BITS-1:0] o_found_link,
    output logic [7:0]           o_found_role,
    output logic [15:0]          o_found_caps,
    output logic [15:0]          o_found_seq,
    output logic [7:0]           o_found_strength,
    output logic [31:0]          o_found_seen,
    output logic [4:0]           o_expired_count,
    output logic [4:0]           o_occupied_count
);
    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int PW = LINK_BITS + 8 + 16 + 16 + 8 + 32;
    localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

    logic [1:0]          r_state_arr [ENTRIES];
    logic [KEY_BITS-1:0] r_key [ENTRIES];
    logic [31:0]         r_seen [ENTRIES];
    logic [PW-1:0]       mem_pay [ENTRIES];

    logic [31:0]          r_timeout;
    logic [CW-1:0]        r_used;
    logic [2:0]           r_cmd;
    logic [KEY_BITS-1:0]  r_key_in;
    logic [PW-1:0]        r_pay_in;
    logic [31:0]          r_now;
    logic [IW-1:0]        r_ptr;
    logic                 r_hit, r_emp;
    logic [IW-1:0]        r_hit_idx, r_emp_idx;
    logic [CW-1:0]        r_exp;
    logic [PW-1:0]        r_rd;

    logic [1:0]  r_status;
    logic [IW-1:0] r_slot;

    logic scan_active;
    logic scan_match;
    logic scan_expire;
    logic bcast;
    logic [31:0] age;

    assign bcast       = (r_key_in == '1);
    assign age         = r_now - r_seen[r_ptr];
    assign scan_match  = (r_state_arr[r_ptr] != ntwa_pkg::ST_EMPTY) && (r_key[r_ptr] == r_key_in);
    assign scan_expire = (r_state_arr[r_ptr] == ntwa_pkg::ST_ACTIVE) && (age >= r_timeout);
    assign scan_active = i_ctl.scan_step;
    assign o_sts.scan_last = (r_ptr == LAST);

    // Input capture, payload store and payload read.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd    <= i_cmd;
            r_key_in <= i_node_address;
            r_pay_in <= {i_link_address, i_node_role, i_capability_bits,
                         i_seq_number, i_signal_strength, i_now_time};
            r_now    <= i_now_time;
        end
        if (i_ctl.act && r_cmd == ntwa_pkg::CMD_UPDATE && !bcast && (r_hit || r_emp)) begin
            mem_pay[r_hit ? r_hit_idx : r_emp_idx] <= r_pay_in;
        end
        if (i_ctl.rd) begin
            r_rd <= mem_pay[r_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= '0;
            r_used    <= '0;
            r_ptr     <= '0;
            r_hit     <= 1'b0;
            r_emp     <= 1'b0;
            r_hit_idx <= '0;
            r_emp_idx <= '0;
            r_exp     <= '0;
            r_status  <= ntwa_pkg::RES_OK;
            r_slot    <= '0;
            for (int i = 0; i < ENTRIES; i++) r_state_arr[i] <= ntwa_pkg::ST_EMPTY;
        end else begin
            if (i_cfg_we) r_timeout <= i_cfg_data;
            if (i_ctl.scan_clr) begin
                r_ptr <= '0;
                r_hit <= 1'b0;
                r_emp <= 1'b0;
                r_exp <= '0;
            end
            if (scan_active) begin
                if (!o_sts.scan_last) r_ptr <= r_ptr + 1'b1;
                if (scan_match && !r_hit) begin
                    r_hit     <= 1'b1;
                    r_hit_idx <= r_ptr;
                end
                if (r_state_arr[r_ptr] == ntwa_pkg::ST_EMPTY && !r_emp) begin
                    r_emp     <= 1'b1;
                    r_emp_idx <= r_ptr;
                end
                if (r_cmd == ntwa_pkg::CMD_EXPIRE && scan_expire) begin
                    r_state_arr[r_ptr] <= ntwa_pkg::ST_STALE;
                    r_exp <= r_exp + 1'b1;
                end
            end
            if (i_ctl.act) begin
                r_status <= ntwa_pkg::RES_OK;
                r_slot   <= '0;
                case (r_cmd)
                    ntwa_pkg::CMD_UPDATE: begin
                        if (bcast) begin
                            r_status <= ntwa_pkg::RES_INVALID;
                        end else if (r_hit) begin
                            r_state_arr[r_hit_idx] <= ntwa_pkg::ST_ACTIVE;
                            r_seen[r_hit_idx]      <= r_now;
                            r_slot                 <= r_hit_idx;
                        end else if (r_emp) begin
                            r_state_arr[r_emp_idx] <= ntwa_pkg::ST_ACTIVE;
                            r_seen[r_emp_idx]      <= r_now;
                            r_key[r_emp_idx]       <= r_key_in;
                            r_slot                 <= r_emp_idx;
                            r_used                 <= r_used + 1'b1;
                        end else begin
                            r_status <= ntwa_pkg::RES_FULL;
                        end
                    end
                    ntwa_pkg::CMD_LOOKUP: begin
                        if (r_hit) r_slot <= r_hit_idx;
                        else r_status <= ntwa_pkg::RES_NOT_FOUND;
                    end
                    ntwa_pkg::CMD_REMOVE: begin
                        if (r_hit) begin
                            r_slot <= r_hit_idx;
                            r_state_arr[r_hit_idx] <= ntwa_pkg::ST_EMPTY;
                            if (r_used != '0) r_used <= r_used - 1'b1;
                        end else begin
                            r_status <= ntwa_pkg::RES_NOT_FOUND;
                        end
                    end
                    ntwa_pkg::CMD_EXPIRE: ;
                    ntwa_pkg::CMD_CLEAR: begin
                        for (int i = 0; i < ENTRIES; i++)
                            r_state_arr[i] <= ntwa_pkg::ST_EMPTY;
                        r_used <= '0;
                    end
                    default: r_status <= ntwa_pkg::RES_INVALID;
                endcase
            end
        end
    end

    // Result word, held until the controller leaves the done state.
    logic r_lk_hit;
    logic [1:0] r_est;
    always_ff @(posedge i_clk) begin
        if (i_ctl.finish) begin
            r_lk_hit <= (r_cmd == ntwa_pkg::CMD_LOOKUP) && r_hit;
            r_est    <= r_state_arr[r_slot];
        end
    end

    logic lk_cmd;
    assign lk_cmd = r_lk_hit;
    assign o_status         = r_status;
    assign o_slot_index     = 4'(r_slot);
    assign o_entry_status   = lk_cmd ? r_est : ntwa_pkg::ST_EMPTY;
    assign o_found_link     = lk_cmd ? r_rd[PW-1 -: LINK_BITS] : '0;
    assign o_found_role     = lk_cmd ? r_rd[79:72] : '0;
    assign o_found_caps     = lk_cmd ? r_rd[71:56] : '0;
    assign o_found_seq      = lk_cmd ? r_rd[55:40] : '0;
    assign o_found_strength = lk_cmd ? r_rd[39:32] : '0;
    assign o_found_seen     = lk_cmd ? r_seen[r_slot] : '0;
    assign o_expired_count  = (r_cmd == ntwa_pkg::CMD_EXPIRE) ? 5'(r_exp) : '0;
    assign o_occupied_count = 5'(r_used);
endmodule

>>> hw/rtl/neighbor_table_with_aging.sv
`timescale 1ns / 1ps
// Neighbor table with aging.
// A command word enters on in_ch (valid/ready) and exactly one result word
// leaves on out_ch. Commands: update, lookup, remove, expire and clear.
// The block works on one word at a time: it accepts a word only when idle,
// then scans the table one slot per cycle to find the key match, the first
// empty slot and, for expire, the aged entries. The ACT state then applies
// the command and the READ state reads the slot payload memory, after which
// the DONE state raises out_ch.valid.
// The result word is held in registers while the receiver stalls; no new
// word is taken until it is delivered.
// Reset (synchronous, active low) empties every slot, zeroes the occupied
// count and the timeout. Slot payloads are not cleared; they are only output
// for occupied slots. The aging timeout is written through i_cfg_we/i_cfg_data
// while the block is idle; the user must keep to this, the block does not enforce it.
module neighbor_table_with_aging #(
    parameter int ENTRIES   = 16,
    parameter int KEY_BITS  = 48,
    parameter int LINK_BITS = 48
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_data,
    ntwa_in_if.sink     in_ch,
    ntwa_out_if.source  out_ch
);
    ntwa_pkg::t_ctl ctl;
    ntwa_pkg::t_sts sts;
    logic [7:0] strength;

    ntwa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_ch.valid),
        .o_in_ready (in_ch.ready),
        .o_out_valid(out_ch.valid),
        .i_out_ready(out_ch.ready),
        .i_sts      (sts),
        .o_ctl      (ctl)
    );

    ntwa_datapath #(
        .ENTRIES(ENTRIES), .KEY_BITS(KEY_BITS), .LINK_BITS(LINK_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ctl            (ctl),
        .o_sts            (sts),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_cmd            (in_ch.cmd),
        .i_node_address   (in_ch.node_address),
        .i_link_address   (in_ch.link_address),
        .i_node_role      (in_ch.node_role),
        .i_capability_bits(in_ch.capability_bits),
        .i_seq_number     (in_ch.seq_number),
        .i_signal_strength(in_ch.signal_strength),
        .i_now_time       (in_ch.now_time),
        .o_status         (out_ch.status),
        .o_slot_index     (out_ch.slot_index),
        .o_entry_status   (out_ch.entry_status),
        .o_found_link     (out_ch.found_link_address),
        .o_found_role     (out_ch.found_role),
        .o_found_caps     (out_ch.found_capabilities),
        .o_found_seq      (out_ch.found_sequence),
        .o_found_strength (strength),
        .o_found_seen     (out_ch.found_last_seen),
        .o_expired_count  (out_ch.expired_count),
        .o_occupied_count (out_ch.occupied_count)
    );
    assign out_ch.found_strength = strength;

`ifndef SYNTHESIS
    // The block never offers input while a result is pending.
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(in_ch.ready && out_ch.valid)) else $error("ready while result pending");
    // An accepted word always leads to scanning in the next cycle.
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_ch.valid && in_ch.ready) |=> ctl.scan_step) else $error("scan not started");
    // The occupied count never exceeds the table size.
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_ch.occupied_count <= 5'(ENTRIES)) else $error("count overflow");
`endif
endmodule
